>>> rtl/core/ipv4hv_pkg.sv
package ipv4hv_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_SHORT_CAPTURE = 3'd1,
    ST_BAD_START     = 3'd2,
    ST_BAD_LENGTH    = 3'd3,
    ST_BAD_CHECKSUM  = 3'd4,
    ST_TRUNCATED     = 3'd5
  } status_e;

  // Configuration register indexes
  localparam logic CFG_MIN_START = 1'b0;
  localparam logic CFG_MAX_START = 1'b1;

  localparam logic [7:0]  MIN_START_RESET = 8'd69;
  localparam logic [7:0]  MAX_START_RESET = 8'd79;
  localparam logic [15:0] HDR_MIN_BYTES   = 16'd20;
  localparam logic [15:0] SUM_START       = 16'hFFFF;

  typedef struct packed {
    status_e     status;
    logic [5:0]  header_length;
    logic [15:0] total_length;
  } result_t;

  // Ones'-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

>>> rtl/core/ipv4_header_validator.sv
// A transferred byte lands in the input register and is checked by the core as it
// advances; its result (if any) is registered in the output register or skid slot.
// Throughput: one byte per cycle while the skid slot is empty; the per-byte checksum
// add and length compares sit between the input register and the result register.
// Reset: asynchronous, active low; clears bounds to 69/79 and leaves the block idle
// until a byte with start_req set arrives.
module ipv4_header_validator import ipv4hv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // byte stream in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  input  logic [15:0] captured_length_i,
  // verdict out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [5:0]  header_length_o,
  output logic [15:0] total_length_o
);

  // Configuration registers: always ready; written only while idle is a user rule the block does not enforce.
  logic [7:0] min_start_q, max_start_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_start_q <= MIN_START_RESET;
      max_start_q <= MAX_START_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_START: min_start_q <= cfg_data_i;
        CFG_MAX_START: max_start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: holds one byte until the checker can take it.
  logic        stage_valid_q;
  logic [7:0]  stage_byte_q;
  logic        stage_start_q;
  logic [15:0] stage_cap_q;
  logic        in_fire;
  logic        advance;

  // Output register plus skid slot. The skid slot only fills while the output
  // register is stalled, so the stage may advance whenever the skid is empty.
  logic        out_valid_q;
  result_t     out_q;
  logic        skid_valid_q;
  result_t     skid_q;
  logic        out_free;

  logic        res_valid;
  result_t     res;

  assign advance    = stage_valid_q && !skid_valid_q;
  assign in_ready_o = !stage_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_fire) begin
      stage_valid_q <= 1'b1;
    end else if (advance) begin
      stage_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_byte_q  <= data_byte_i;
      stage_start_q <= start_req_i;
      stage_cap_q   <= captured_length_i;
    end
  end

  // Per-packet state and verdict logic.
  ipv4hv_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .min_start_i       (min_start_q),
    .max_start_i       (max_start_q),
    .item_valid_i      (advance),
    .data_byte_i       (stage_byte_q),
    .start_req_i       (stage_start_q),
    .captured_length_i (stage_cap_q),
    .res_valid_o       (res_valid),
    .res_o             (res)
  );

  // Result delivery: drain skid first, otherwise take a fresh verdict; when
  // the output is stalled, park the fresh verdict in the skid slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign header_length_o = out_q.header_length;
  assign total_length_o  = out_q.total_length;

endmodule

>>> rtl/core/ipv4hv_core.sv
module ipv4hv_core import ipv4hv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  min_start_i,
  input  logic [7:0]  max_start_i,
  input  logic        item_valid_i,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  input  logic [15:0] captured_length_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  logic [5:0]  byte_index_q, byte_index_d;
  logic [15:0] running_sum_q, running_sum_d;
  logic [7:0]  high_byte_hold_q, high_byte_hold_d;
  logic [5:0]  header_bytes_q, header_bytes_d;
  logic [15:0] packet_length_q, packet_length_d;
  logic [15:0] capture_limit_q, capture_limit_d;
  logic        verdict_given_q, verdict_given_d;
  logic [6:0]  idx_inc;
  status_e     status;

  always_comb begin
    byte_index_d     = byte_index_q;
    running_sum_d    = running_sum_q;
    high_byte_hold_d = high_byte_hold_q;
    header_bytes_d   = header_bytes_q;
    packet_length_d  = packet_length_q;
    capture_limit_d  = capture_limit_q;
    verdict_given_d  = verdict_given_q;
    res_valid_o      = 1'b0;
    status           = ST_OK;
    idx_inc          = {1'b0, byte_index_q} + 7'd1;

    if (item_valid_i) begin
      if (start_req_i) begin
        capture_limit_d  = captured_length_i;
        header_bytes_d   = {data_byte_i[3:0], 2'b00};
        byte_index_d     = 6'd1;
        running_sum_d    = SUM_START;
        high_byte_hold_d = data_byte_i;
        packet_length_d  = 16'd0;
        verdict_given_d  = 1'b0;
        if (captured_length_i < HDR_MIN_BYTES) begin
          res_valid_o = 1'b1;
          status      = ST_SHORT_CAPTURE;
        end else if (data_byte_i < min_start_i || data_byte_i > max_start_i) begin
          res_valid_o = 1'b1;
          status      = ST_BAD_START;
        end
      end else if (!verdict_given_q) begin
        if (byte_index_q[0]) begin
          if (byte_index_q < header_bytes_q) begin
            running_sum_d = oc_add(running_sum_q, {high_byte_hold_q, data_byte_i});
          end
        end else begin
          high_byte_hold_d = data_byte_i;
        end
        if (byte_index_q == 6'd2) begin
          packet_length_d = {data_byte_i, 8'd0};
        end else if (byte_index_q == 6'd3) begin
          packet_length_d = {packet_length_q[15:8], data_byte_i};
        end
        byte_index_d = idx_inc[5:0];

        if (byte_index_q == 6'd3 && packet_length_d < HDR_MIN_BYTES) begin
          res_valid_o = 1'b1;
          status      = ST_BAD_LENGTH;
        end else if (byte_index_q >= 6'd3 && idx_inc >= {1'b0, header_bytes_q}) begin
          res_valid_o = 1'b1;
          if (header_bytes_q == 6'd0 || running_sum_d != SUM_START) begin
            status = ST_BAD_CHECKSUM;
          end else if (packet_length_d > capture_limit_q) begin
            status = ST_TRUNCATED;
          end else begin
            status = ST_OK;
          end
        end
      end
      if (res_valid_o) begin
        verdict_given_d = 1'b1;
      end
    end

    res_o.status        = status;
    res_o.header_length = header_bytes_d;
    res_o.total_length  = packet_length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q     <= 6'd0;
      running_sum_q    <= SUM_START;
      high_byte_hold_q <= 8'd0;
      header_bytes_q   <= 6'd0;
      packet_length_q  <= 16'd0;
      capture_limit_q  <= 16'd0;
      verdict_given_q  <= 1'b1;
    end else begin
      byte_index_q     <= byte_index_d;
      running_sum_q    <= running_sum_d;
      high_byte_hold_q <= high_byte_hold_d;
      header_bytes_q   <= header_bytes_d;
      packet_length_q  <= packet_length_d;
      capture_limit_q  <= capture_limit_d;
      verdict_given_q  <= verdict_given_d;
    end
  end

endmodule

>>> rtl/core/ipv4hv_checker.sv
module ipv4hv_checker import ipv4hv_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [5:0]  header_length_o,
  input logic [15:0] total_length_o
);

  // A stalled verdict stays up with the same payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable(status_o) && $stable(header_length_o) && $stable(total_length_o))
    else $error("stalled verdict dropped or changed");

  // Backpressure on the input only happens with a verdict waiting on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Header length is IHL times four.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> header_length_o[1:0] == 2'b00)
    else $error("header length not a multiple of four");

  // Verdicts reached before the length field report zero total length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_SHORT_CAPTURE || status_o == ST_BAD_START)
      |-> total_length_o == 16'd0)
    else $error("early verdict carries a total length");

  // Verdicts after the length check carry a total length of at least twenty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK || status_o == ST_TRUNCATED ||
      status_o == ST_BAD_CHECKSUM) |-> total_length_o >= HDR_MIN_BYTES)
    else $error("late verdict with short total length");

endmodule

bind ipv4_header_validator ipv4hv_checker u_ipv4hv_checker (.*);

>>> test/ipv4_header_validator_tb.sv
`timescale 1ns / 1ps

module ipv4_header_validator_tb;
  import ipv4hv_pkg::*;

  // Abort when this many cycles pass with no transfer on any channel.
  localparam int STALL_LIMIT = 2000;

  // Keeps its own copy of the validator state and bounds. It works out the
  // verdicts from the transferred bytes and holds the verdicts still owed.
  class verdict_board;
    logic [7:0]  lo_bound;
    logic [7:0]  hi_bound;
    logic [5:0]  next_idx;
    logic [5:0]  hdr_len;
    logic [15:0] hdr_sum;
    logic [15:0] tot_len;
    logic [15:0] cap_len;
    logic [7:0]  hi_hold;
    bit          settled;
    result_t     verdict_q[$];
    int          errors;

    function new();
      lo_bound = MIN_START_RESET;
      hi_bound = MAX_START_RESET;
      next_idx = '0;
      hdr_len  = '0;
      hdr_sum  = SUM_START;
      tot_len  = '0;
      cap_len  = '0;
      hi_hold  = '0;
      settled  = 1'b1;
      errors   = 0;
    endfunction

    function void set_bound(logic idx, logic [7:0] val);
      if (idx == CFG_MIN_START) begin
        lo_bound = val;
      end else begin
        hi_bound = val;
      end
    endfunction

    static function logic [15:0] ones_fold(logic [15:0] acc, logic [15:0] word);
      int unsigned s;
      s = acc + word;
      s = (s & 32'hFFFF) + (s >> 16);
      return s[15:0];
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void give(status_e st);
      result_t r;
      r.status        = st;
      r.header_length = hdr_len;
      r.total_length  = tot_len;
      verdict_q.push_back(r);
      settled = 1'b1;
    endfunction

    // Returns 1 when the byte takes part in a packet, 0 when it is dropped.
    function bit note_transfer(logic [7:0] d, logic first, logic [15:0] cap);
      int i;
      if (first) begin
        cap_len  = cap;
        hdr_len  = {d[3:0], 2'b00};
        next_idx = 6'd1;
        hdr_sum  = SUM_START;
        hi_hold  = d;
        tot_len  = '0;
        settled  = 1'b0;
        if (cap < HDR_MIN_BYTES) begin
          give(ST_SHORT_CAPTURE);
        end else if (d < lo_bound || d > hi_bound) begin
          give(ST_BAD_START);
        end
        return 1'b1;
      end
      if (settled) return 1'b0;
      i = next_idx;
      // odd bytes close a big-endian word, even bytes open one
      if (i % 2 == 1) begin
        if (i < hdr_len) hdr_sum = ones_fold(hdr_sum, {hi_hold, d});
      end else begin
        hi_hold = d;
      end
      if (i == 2) begin
        tot_len = {d, 8'h00};
      end else if (i == 3) begin
        tot_len[7:0] = d;
      end
      next_idx = next_idx + 6'd1;
      if (i == 3 && tot_len < HDR_MIN_BYTES) begin
        give(ST_BAD_LENGTH);
      end else if (i >= 3 && i + 1 >= hdr_len) begin
        if (hdr_len == 0 || hdr_sum != 16'hFFFF) begin
          give(ST_BAD_CHECKSUM);
        end else if (tot_len > cap_len) begin
          give(ST_TRUNCATED);
        end else begin
          give(ST_OK);
        end
      end
      return 1'b1;
    endfunction

    function void flag(string what, logic [15:0] want, logic [15:0] got);
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [2:0] st, logic [5:0] hl, logic [15:0] tl);
      result_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: verdict expected none, got status %0d header %0d total %0d",
                 $time, st, hl, tl);
        return;
      end
      want = verdict_q.pop_front();
      if (want.status != st) flag("status", 16'(want.status), 16'(st));
      if (want.header_length != hl) flag("header length", 16'(want.header_length), 16'(hl));
      if (want.total_length != tl) flag("total length", want.total_length, tl);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = CFG_MIN_START;
  logic [7:0]  cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_data   = '0;
  logic        in_start  = 1'b0;
  logic [15:0] in_cap    = '0;
  logic        out_ready = 1'b0;
  wire         cfg_ready;
  wire         in_ready;
  wire         out_valid;
  wire  [2:0]  out_status;
  wire  [5:0]  out_hdr_len;
  wire  [15:0] out_tot_len;

  verdict_board sb;
  int send_idle_pct = 23;
  int recv_idle_pct = 48;
  int fed_items     = 0;
  int quiet_cycles  = 0;

  ipv4_header_validator u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .data_byte_i       (in_data),
    .start_req_i       (in_start),
    .captured_length_i (in_cap),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (out_status),
    .header_length_o   (out_hdr_len),
    .total_length_o    (out_tot_len)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check each verdict transfer, then pick the next cycle's ready at random.
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_result(out_status, out_hdr_len, out_tot_len);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Count cycles with no transfer on any channel; give up when stuck.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Transfer one byte. Idle at random first, then hold valid until ready.
  task automatic push_byte(input logic [7:0] d, input logic first, input logic [15:0] cap);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    in_start <= first;
    in_cap   <= cap;
    do @(posedge clk); while (!in_ready);
    void'(sb.note_transfer(d, first, cap));
    fed_items++;
  endtask

  // Drop valid, wait for every owed verdict, then let the pipeline empty.
  task automatic settle_verdicts();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both start-byte bounds back to back; lower valid only at the end.
  task automatic write_bounds(input logic [7:0] lo, input logic [7:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MIN_START;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    sb.set_bound(CFG_MIN_START, lo);
    cfg_index <= CFG_MAX_START;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    sb.set_bound(CFG_MAX_START, hi);
    cfg_valid <= 1'b0;
  endtask

  // Send one packet: mostly a well-formed header with random content and a
  // checksum that usually holds, sometimes cut short so the next start
  // abandons it, and sometimes plain noise.
  task automatic push_packet();
    logic [7:0]  pkt [64];
    logic [15:0] tl;
    logic [15:0] cap;
    logic [15:0] acc;
    int          kind;
    int          hlen;
    int          base;
    int          nsend;
    int          k;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      push_byte(8'($urandom), 1'b1, 16'($urandom));
      repeat ($urandom_range(8)) push_byte(8'($urandom), $urandom_range(9) == 0, 16'($urandom));
    end else begin
      for (k = 0; k < 64; k++) pkt[k] = 8'($urandom);
      case ($urandom_range(9))
        0:       pkt[0] = 8'($urandom);
        1, 2:    pkt[0] = {4'h4, 4'($urandom_range(6, 15))};
        default: pkt[0] = 8'h45;
      endcase
      hlen = pkt[0][3:0] * 4;
      base = (hlen > 20) ? hlen : 20;
      case ($urandom_range(9))
        0:       tl = 16'($urandom_range(19));
        1:       tl = 16'($urandom);
        default: tl = 16'(base + $urandom_range(200));
      endcase
      {pkt[2], pkt[3]} = tl;
      // patch the checksum word so the header sums to all ones, most of the time
      if (hlen >= 12) begin
        pkt[10] = 8'h00;
        pkt[11] = 8'h00;
        acc = SUM_START;
        for (k = 0; k + 1 < hlen; k += 2) begin
          acc = verdict_board::ones_fold(acc, {pkt[k], pkt[k + 1]});
        end
        if ($urandom_range(9) != 0) {pkt[10], pkt[11]} = ~acc;
      end
      case ($urandom_range(9))
        0:       cap = 16'($urandom);
        1, 2:    cap = (tl > 30) ? tl - 16'($urandom_range(1, 10)) : tl;
        3:       cap = 16'($urandom_range(19));
        default: cap = (tl > 16'hFFD7) ? 16'hFFFF : tl + 16'($urandom_range(40));
      endcase
      // trailing bytes past the verdict get dropped by the block
      nsend = ((hlen > 4) ? hlen : 4) + $urandom_range(3);
      if (kind >= 70) nsend = $urandom_range(1, nsend - 1);
      push_byte(pkt[0], 1'b1, cap);
      for (k = 1; k < nsend; k++) push_byte(pkt[k], 1'b0, 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset bounds.
    push_byte(8'hA5, 1'b0, 16'hFFFF);   // byte with no packet open: dropped
    push_byte(8'h45, 1'b1, 16'd0);      // empty capture
    push_byte(8'h45, 1'b1, 16'd19);     // capture one short of a header
    push_byte(8'h44, 1'b1, 16'd20);     // first byte just below the window
    push_byte(8'h50, 1'b1, 16'hFFFF);   // first byte just above the window
    push_byte(8'h45, 1'b1, 16'd40);     // open a packet, then restart it
    push_byte(8'h00, 1'b0, 16'd0);
    push_byte(8'h4F, 1'b1, 16'hFFFF);   // restart: total length 19 fails
    push_byte(8'hFF, 1'b0, 16'h0000);
    push_byte(8'h00, 1'b0, 16'hFFFF);
    push_byte(8'h13, 1'b0, 16'h0000);
    settle_verdicts();

    // Open the window fully: zero header length must fail the checksum.
    write_bounds(8'd0, 8'd255);
    push_byte(8'h40, 1'b1, 16'd20);
    push_byte(8'h00, 1'b0, 16'd0);
    push_byte(8'h00, 1'b0, 16'd0);
    push_byte(8'h14, 1'b0, 16'd0);
    push_byte(8'h00, 1'b1, 16'd20);
    push_byte(8'hFF, 1'b0, 16'hFFFF);
    push_byte(8'hFF, 1'b0, 16'hFFFF);
    push_byte(8'hFF, 1'b0, 16'hFFFF);
    settle_verdicts();

    // Crossed bounds reject every first byte.
    write_bounds(8'd200, 8'd10);
    push_byte(8'h45, 1'b1, 16'd100);
    push_byte(8'hC8, 1'b1, 16'd100);
    settle_verdicts();

    // Random traffic, phase one: sender idles less than the receiver.
    write_bounds(8'd0, 8'd255);
    while (fed_items < 500) begin
      push_packet();
      if ($urandom_range(39) == 0) settle_verdicts();
    end
    settle_verdicts();

    // Phase two: swap the idle rates, back to the reset window.
    send_idle_pct = 48;
    recv_idle_pct = 23;
    write_bounds(MIN_START_RESET, MAX_START_RESET);
    while (fed_items < 980) begin
      push_packet();
      if ($urandom_range(39) == 0) settle_verdicts();
    end
    settle_verdicts();

    // Phase three: full rate on both sides, every IHL of version four allowed.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_bounds(8'd64, 8'd79);
    while (fed_items < 1450) begin
      push_packet();
      if ($urandom_range(39) == 0) settle_verdicts();
    end
    settle_verdicts();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> ipv4_header_validator.f
rtl/core/ipv4hv_pkg.sv
rtl/core/ipv4hv_core.sv
rtl/core/ipv4_header_validator.sv
rtl/core/ipv4hv_checker.sv
test/ipv4_header_validator_tb.sv
